// ----- sv/sector_cache_clock_replacement_defines.svh -----
// Assertion macros for the sector cache replacement engine.
// Both sample on clk and are quiet while arst_n is low.
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH

// cons must hold in the same cycle as ante
`define SCCR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define SCCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sccr_pkg.sv -----
`default_nettype none
package sccr_pkg;

	localparam int ENTRIES     = 64;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int SECTOR_BITS = 32;
	localparam int SLOT_OUT_W  = 6;

	typedef logic [1:0]             action_t;
	typedef logic [SECTOR_BITS-1:0] sector_t;
	typedef logic [SLOT_OUT_W-1:0]  slot_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	localparam action_t ACT_READ  = 2'd0;
	localparam action_t ACT_WRITE = 2'd1;
	localparam action_t ACT_FLUSH = 2'd2;
	localparam action_t ACT_NONE  = 2'd3;

	// next slot, wrapping at the last entry
	function automatic idx_t idx_next(input idx_t i);
		idx_t r;
		if (i == idx_t'(ENTRIES - 1)) begin
			r = '0;
		end else begin
			r = i + idx_t'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/sector_cache_clock_replacement.sv -----
// Sector cache replacement engine: tag and clock (second chance) policy for a
// fully associative cache of disk sectors.
// Input channel: in_valid / in_stall with action (read, write, flush) and
// sector. A word is taken when in_valid is high and in_stall low; in_stall is
// high for the whole time a request is being worked on.
// Output channel: out_valid / out_stall with hit, slot, victim_valid,
// victim_sector, victim_dirty, last. One result register; a stalled result
// holds until taken, and the engine waits on it before loading the next.
// Lookup: the tag memory is walked one slot a cycle through its single read
// port, and a hit ends the walk at the matching slot; a miss walks every
// slot, then the hand sweeps (at most two turns) to pick a slot, whose old
// tag is read for the eviction if it is valid, and the install follows. A
// flush scans the slots in order and gives one result word per valid slot.
// Action three is taken and dropped with no result.
// Reset clears valid, use and dirty bits and the hand at once; the tag
// memory is not cleared and its data is only ever used behind a set valid bit.
`default_nettype none
`include "sector_cache_clock_replacement_defines.svh"
module sector_cache_clock_replacement (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  sccr_pkg::action_t      action,
	input  sccr_pkg::sector_t      sector,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   hit,
	output sccr_pkg::slot_t        slot,
	output logic                   victim_valid,
	output sccr_pkg::sector_t      victim_sector,
	output logic                   victim_dirty,
	output logic                   last
);
	import sccr_pkg::*;

	// sequencer codes
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_LOOKUP  = 3'd1;
	localparam logic [2:0] ST_HIT     = 3'd2;
	localparam logic [2:0] ST_SWEEP   = 3'd3;
	localparam logic [2:0] ST_INST    = 3'd4;
	localparam logic [2:0] ST_FL_SCAN = 3'd5;
	localparam logic [2:0] ST_FL_EMIT = 3'd6;

	logic [2:0]         state_q;
	cnt_t               idx_q;      // lookup issue counter / flush index
	idx_t               hand_q;
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] use_q;
	logic [ENTRIES-1:0] dirty_q;

	sector_t            sector_q;
	logic               write_q;
	idx_t               slot_q;     // hit slot or install target
	logic               vic_valid_q;
	logic               vic_dirty_q;

	// tag memory, one read and one write port, registered read
	sector_t            tag_mem [ENTRIES];
	sector_t            rd_data_q;
	idx_t               rd_addr;
	logic               rd_en;
	logic               mem_we;

	// lookup compare stage, aligned with rd_data_q
	logic               lk_act_s1;
	logic               lk_vld_s1;
	idx_t               lk_slot_s1;

	// result register
	logic               out_valid_q;
	logic               hit_q;
	slot_t              slot_out_q;
	logic               vv_q;
	sector_t            vs_q;
	logic               vd_q;
	logic               last_q;

	logic               in_acc;
	logic               out_free;
	logic               out_load;
	idx_t               fl_idx;
	idx_t               lk_idx;
	logic               lk_issue;
	logic               lk_hit;
	logic               lk_end;
	logic               sw_evict;
	logic               fl_last;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign fl_idx   = idx_q[IDX_W-1:0];
	assign lk_idx   = idx_q[IDX_W-1:0];

	// the single shared comparator: one stored tag against the request a cycle
	assign lk_hit   = (state_q == ST_LOOKUP) && lk_act_s1 && lk_vld_s1
		&& (rd_data_q == sector_q);
	assign lk_end   = (state_q == ST_LOOKUP) && lk_act_s1
		&& (lk_slot_s1 == idx_t'(ENTRIES - 1));
	assign lk_issue = (state_q == ST_LOOKUP) && (idx_q < cnt_t'(ENTRIES))
		&& !lk_hit && !lk_end;

	// valid slot with its second chance used up
	assign sw_evict = (state_q == ST_SWEEP) && valid_q[hand_q] && !use_q[hand_q];

	// nothing else left once this slot is cleared (lower slots already are)
	assign fl_last  = ((valid_q & ~(ENTRIES'(1) << fl_idx)) == '0);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = fl_idx;
		case (state_q)
			ST_LOOKUP: begin
				rd_en   = lk_issue;
				rd_addr = lk_idx;
			end
			ST_SWEEP: begin
				rd_en   = sw_evict;
				rd_addr = hand_q;
			end
			ST_FL_SCAN: begin
				rd_en   = valid_q[fl_idx];
				rd_addr = fl_idx;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = fl_idx;
			end
		endcase
	end

	assign out_load = out_free && ((state_q == ST_HIT) || (state_q == ST_INST)
		|| (state_q == ST_FL_EMIT));
	assign mem_we   = out_free && (state_q == ST_INST);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[slot_q] <= sector_q;
		end
		if (rd_en) begin
			rd_data_q <= tag_mem[rd_addr];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			hand_q      <= '0;
			valid_q     <= '0;
			use_q       <= '0;
			dirty_q     <= '0;
			lk_act_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			lk_act_s1 <= lk_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_acc) begin
						if (action == ACT_FLUSH) begin
							state_q <= ST_FL_SCAN;
						end else if (action == ACT_READ || action == ACT_WRITE) begin
							state_q <= ST_LOOKUP;
						end
					end
				end
				ST_LOOKUP: begin
					if (lk_issue) begin
						idx_q <= idx_q + cnt_t'(1);
					end
					if (lk_hit) begin
						state_q <= ST_HIT;
					end else if (lk_end) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_HIT: begin
					if (out_free) begin
						use_q[slot_q] <= 1'b1;
						if (write_q) begin
							dirty_q[slot_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					hand_q <= idx_next(hand_q);
					if (!valid_q[hand_q] || sw_evict) begin
						state_q <= ST_INST;
					end else begin
						use_q[hand_q] <= 1'b0;
					end
				end
				ST_INST: begin
					if (out_free) begin
						valid_q[slot_q] <= 1'b1;
						use_q[slot_q]   <= 1'b1;
						dirty_q[slot_q] <= write_q;
						state_q         <= ST_IDLE;
					end
				end
				ST_FL_SCAN: begin
					if (valid_q[fl_idx]) begin
						state_q <= ST_FL_EMIT;
					end else if (fl_idx == idx_t'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + cnt_t'(1);
					end
				end
				ST_FL_EMIT: begin
					if (out_free) begin
						valid_q[fl_idx] <= 1'b0;
						use_q[fl_idx]   <= 1'b0;
						dirty_q[fl_idx] <= 1'b0;
						if (fl_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + cnt_t'(1);
							state_q <= ST_FL_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sector_q <= sector;
			write_q  <= (action == ACT_WRITE);
		end
		if (lk_issue) begin
			lk_slot_s1 <= lk_idx;
			lk_vld_s1  <= valid_q[lk_idx];
		end
		if (lk_hit) begin
			slot_q <= lk_slot_s1;
		end
		if (state_q == ST_SWEEP) begin
			slot_q      <= hand_q;
			vic_valid_q <= sw_evict;
			vic_dirty_q <= dirty_q[hand_q];
		end
		if (out_load) begin
			case (state_q)
				ST_HIT: begin
					hit_q      <= 1'b1;
					slot_out_q <= slot_t'(slot_q);
					vv_q       <= 1'b0;
					vs_q       <= '0;
					vd_q       <= 1'b0;
					last_q     <= 1'b1;
				end
				ST_INST: begin
					hit_q      <= 1'b0;
					slot_out_q <= slot_t'(slot_q);
					vv_q       <= vic_valid_q;
					vs_q       <= vic_valid_q ? rd_data_q : '0;
					vd_q       <= vic_valid_q && vic_dirty_q;
					last_q     <= 1'b1;
				end
				default: begin
					hit_q      <= 1'b0;
					slot_out_q <= slot_t'(fl_idx);
					vv_q       <= 1'b1;
					vs_q       <= rd_data_q;
					vd_q       <= dirty_q[fl_idx];
					last_q     <= fl_last;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_out_q;
	assign victim_valid  = vv_q;
	assign victim_sector = vs_q;
	assign victim_dirty  = vd_q;
	assign last          = last_q;

	`SCCR_ASSERT_SAME(a_hit_no_victim, out_valid, !(hit && victim_valid), "hit word carries a victim")
	`SCCR_ASSERT_NEXT(a_hit_sets_use, (state_q == ST_HIT) && out_load, use_q[$past(slot_q)], "use bit not set after hit")
	`SCCR_ASSERT_NEXT(a_inst_valid, (state_q == ST_INST) && out_load, valid_q[$past(slot_q)] && use_q[$past(slot_q)], "install left slot empty")
	`SCCR_ASSERT_SAME(a_idle_no_load, state_q == ST_IDLE, !out_load && !mem_we, "result or write while idle")

endmodule
`default_nettype wire

// ----- sim/sccr_clock_checker.sv -----
`timescale 1ns / 1ps
module sccr_clock_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_stall,
	input  sccr_pkg::action_t   action,
	input  sccr_pkg::sector_t   sector,
	input  wire                 out_valid,
	input  wire                 out_stall,
	input  wire                 hit,
	input  sccr_pkg::slot_t     slot,
	input  wire                 victim_valid,
	input  sccr_pkg::sector_t   victim_sector,
	input  wire                 victim_dirty,
	input  wire                 last,
	output int                  fail_count,
	output int                  pending,
	output int                  results_seen,
	output int                  hits_seen,
	output int                  writebacks_seen
);
	import sccr_pkg::*;

	typedef struct packed {
		logic    hit;
		slot_t   slot;
		logic    vv;
		sector_t vs;
		logic    vd;
		logic    last;
	} cache_result_t;

	// shadow of the tag and policy state
	sector_t            tags [ENTRIES];
	logic [ENTRIES-1:0] present;
	logic [ENTRIES-1:0] recent;
	logic [ENTRIES-1:0] dirty;
	idx_t               hand_pos;

	cache_result_t due_results[$];
	int errs;
	int n_seen;
	int n_hits;
	int n_wb;

	assign fail_count      = errs;
	assign results_seen    = n_seen;
	assign hits_seen       = n_hits;
	assign writebacks_seen = n_wb;

	initial begin
		errs    = 0;
		n_seen  = 0;
		n_hits  = 0;
		n_wb    = 0;
	end

	// work out the results of one accepted word and update the shadow state
	function automatic void apply_request(input action_t a, input sector_t s);
		cache_result_t r;
		int            last_i;
		logic          found;
		logic          done;
		idx_t          h;
		last_i = -1;
		found  = 1'b0;
		done   = 1'b0;
		h      = '0;
		if (a == ACT_FLUSH) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (present[i]) last_i = i;
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (present[i]) begin
					r      = '0;
					r.slot = slot_t'(i);
					r.vv   = 1'b1;
					r.vs   = tags[i];
					r.vd   = dirty[i];
					r.last = (i == last_i);
					due_results.push_back(r);
				end
			end
			present = '0;
			recent  = '0;
			dirty   = '0;
		end else if (a == ACT_READ || a == ACT_WRITE) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (!found && present[i] && tags[i] == s) begin
					found     = 1'b1;
					recent[i] = 1'b1;
					if (a == ACT_WRITE) dirty[i] = 1'b1;
					r      = '0;
					r.hit  = 1'b1;
					r.slot = slot_t'(i);
					r.last = 1'b1;
					due_results.push_back(r);
				end
			end
			if (!found) begin
				r = '0;
				// second chance sweep; ends within two turns
				while (!done) begin
					h        = hand_pos;
					hand_pos = (h == idx_t'(ENTRIES - 1)) ? idx_t'(0) : h + idx_t'(1);
					if (!present[h]) begin
						done = 1'b1;
					end else if (recent[h]) begin
						recent[h] = 1'b0;
					end else begin
						r.vv = 1'b1;
						r.vs = tags[h];
						r.vd = dirty[h];
						done = 1'b1;
					end
				end
				tags[h]    = s;
				present[h] = 1'b1;
				recent[h]  = 1'b1;
				dirty[h]   = (a == ACT_WRITE);
				r.slot     = slot_t'(h);
				r.last     = 1'b1;
				due_results.push_back(r);
			end
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cache_result_t want;
		if (!arst_n) begin
			present  = '0;
			recent   = '0;
			dirty    = '0;
			hand_pos = '0;
			due_results.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) apply_request(action, sector);
			if (out_valid && !out_stall) begin
				n_seen++;
				if (due_results.size() == 0) begin
					$error("result word with nothing expected: slot %0d", slot);
					errs++;
				end else begin
					want = due_results.pop_front();
					if (want.hit) n_hits++;
					if (want.vv) n_wb++;
					check_field("hit", 32'(want.hit), 32'(hit));
					check_field("slot", 32'(want.slot), 32'(slot));
					check_field("victim_valid", 32'(want.vv), 32'(victim_valid));
					check_field("victim_sector", 32'(want.vs), 32'(victim_sector));
					check_field("victim_dirty", 32'(want.vd), 32'(victim_dirty));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			pending <= due_results.size();
		end
	end

endmodule

// ----- sim/tb_sector_cache_clock_replacement.sv -----
`timescale 1ns / 1ps
module tb_sector_cache_clock_replacement;
	import sccr_pkg::*;

	// settle time after the last result: a flush of a full cache or an
	// ignored word may still be in flight
	localparam int TAIL_CYCLES = 4 * ENTRIES + 16;
	localparam int POOL_SIZE   = 96;   // more than ENTRIES, so misses evict
	localparam int PHASE_WORDS = 65;

	logic    clk;
	logic    arst_n    = 1'b0;
	logic    in_valid  = 1'b0;
	action_t action    = ACT_READ;
	sector_t sector    = '0;
	logic    out_stall = 1'b0;

	logic    in_stall;
	logic    out_valid;
	logic    hit;
	slot_t   slot;
	logic    victim_valid;
	sector_t victim_sector;
	logic    victim_dirty;
	logic    last;

	int fail_count;
	int pending;
	int results_seen;
	int hits_seen;
	int writebacks_seen;

	// idling odds per cycle, in percent, changed per phase
	int idle_pct  = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int words_ignored = 0;

	sector_t pool [POOL_SIZE];

	sector_cache_clock_replacement i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.sector        (sector),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.slot          (slot),
		.victim_valid  (victim_valid),
		.victim_sector (victim_sector),
		.victim_dirty  (victim_dirty),
		.last          (last)
	);

	sccr_clock_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.sector          (sector),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hit             (hit),
		.slot            (slot),
		.victim_valid    (victim_valid),
		.victim_sector   (victim_sector),
		.victim_dirty    (victim_dirty),
		.last            (last),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_seen    (results_seen),
		.hits_seen       (hits_seen),
		.writebacks_seen (writebacks_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver back-pressure, one draw per cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// safety net against a hung engine
	initial begin
		#(20_000_000);
		$display("Test completed with failures");
		$finish;
	end

	// Present one word and hold it until taken. Idle cycles come first, so
	// valid never follows stall. Returns at the accepting edge with valid
	// still high; the caller's next assignment decides what comes after.
	task automatic send_word(input action_t a, input sector_t s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= a;
		sector   <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	// drop valid and hold off until every expected result has come
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	initial begin : stimulus
		int      n;
		int      pick;
		action_t a;
		sector_t s;

		for (int i = 0; i < POOL_SIZE; i++) pool[i] = sector_t'($urandom);
		// extremes live in the pool too, so they come back as hits
		pool[0] = '0;
		pool[1] = '1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: flush while empty gives no word back
		send_word(ACT_FLUSH, '0);
		send_word(ACT_READ, '0);                      // cold miss, slot 0
		send_word(ACT_READ, '1);                      // cold miss, slot 1
		send_word(ACT_READ, '0);                      // read hit
		send_word(ACT_WRITE, '1);                     // write hit marks dirty
		send_word(ACT_WRITE, 32'h8000_0001);          // write miss installs dirty
		send_word(ACT_NONE, '0);                      // dropped, no state change
		words_ignored++;
		send_word(ACT_READ, 32'h7fff_fffe);
		send_word(ACT_READ, 32'h7fff_fffe);           // hit on a clean slot
		send_word(ACT_FLUSH, '1);                     // mixed clean and dirty
		send_word(ACT_READ, '0);                      // hand left where it was
		send_word(ACT_FLUSH, 32'h5555_aaaa);          // single-entry flush
		send_word(ACT_READ, 32'haaaa_5555);
		drain;

		// random phases: none, sender idle, receiver stalls, both lightly
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 85; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 85; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			n = 0;
			while (n < PHASE_WORDS) begin
				pick = $urandom_range(99);
				if (pick < 3) begin
					send_word(ACT_FLUSH, sector_t'($urandom));
					n++;
				end else if (pick < 5) begin
					send_word(ACT_NONE, sector_t'($urandom));
					words_ignored++;
				end else begin
					a = ($urandom_range(1) != 0) ? ACT_WRITE : ACT_READ;
					// mostly a reused working set, so hits and evictions mix
					if ($urandom_range(99) < 85) s = pool[$urandom_range(POOL_SIZE - 1)];
					else s = sector_t'($urandom);
					send_word(a, s);
					n++;
				end
			end
			// sender holds off until the engine has answered everything
			drain;
		end

		idle_pct  = 0;
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d request words (%0d of them ignored) across four idling phases.",
			words_sent, words_ignored);
		$display("Checked %0d result words: %0d hits, %0d evictions or flush write-backs.",
			results_seen, hits_seen, writebacks_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sccr_pkg.sv
sv/sector_cache_clock_replacement.sv
sim/sccr_clock_checker.sv
sim/tb_sector_cache_clock_replacement.sv
